@@ rtl/erq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erq_pkg: shared types and constants of the elevator request queue
// Sizes of the stop list, the stored entry layout and the result status codes.
// ----------------------------------------------------------------------------
package erq_pkg;

  localparam int DEPTH   = 16;
  localparam int FLOORS  = 16;
  localparam int FLOOR_W = 4;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REDUNDANT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_SERVE = 1'b1;

  typedef struct packed {
    logic [FLOOR_W-1:0] floor;
    logic               internal;
    logic               up;
  } entry_t;

endpackage

@@ rtl/elevator_request_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_request_queue: ordered list of elevator stop requests
// Adds drop redundant requests, then scan the list and insert in travel order;
// serves pop the head and purge later stops at that floor in the new direction.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | action, request_floor, is_internal,
//          |           |                    | going_up, car_floor
//  out_    | output    | out_valid/out_stall| status, head_valid, head_floor,
//          |           |                    | head_internal, head_up, entry_count
//
//  The list lives in one DEPTH-entry memory with one read and one write port.
//  Add: scans all n entries, then shifts each entry from the insert point on up by one.
//  Serve: walks the list after the head, compacting behind the read pointer.
//  Early drops and empty serves skip the list walk; duplicate or full adds end after the scan.
//  Reset clears the entry count; memory contents stay undefined.
//  One beat at a time; a new beat is taken while the last result waits.
// ----------------------------------------------------------------------------
module elevator_request_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [erq_pkg::FLOOR_W-1:0]     in_request_floor,
  input  logic                            in_is_internal,
  input  logic                            in_going_up,
  input  logic [erq_pkg::FLOOR_W-1:0]     in_car_floor,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [erq_pkg::STATUS_W-1:0]    out_status,
  output logic                            out_head_valid,
  output logic [erq_pkg::FLOOR_W-1:0]     out_head_floor,
  output logic                            out_head_internal,
  output logic                            out_head_up,
  output logic [erq_pkg::CNT_W-1:0]       out_entry_count
);
  import erq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_TAIL  = 3'd3;
  localparam logic [2:0] S_SRV   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  function automatic logic goes_before(entry_t c, logic [FLOOR_W-1:0] af, logic ai,
                                       logic au, logic [FLOOR_W-1:0] prev,
                                       logic [FLOOR_W-1:0] headf);
    logic r;
    if (c.floor == af) begin
      r = 1'b0;
    end else if (headf == af && ((prev > headf && (ai || !au)) ||
                                 (prev < headf && (ai || au)))) begin
      r = 1'b1;
    end else if ((ai && c.internal) || !ai) begin
      r = (prev > c.floor && prev > af && af >= c.floor && (!au || ai)) ||
          (prev < c.floor && prev < af && af <= c.floor && (au || ai));
    end else if ((prev > af && prev > c.floor && c.floor >= af && !c.up) ||
                 (prev < af && prev < c.floor && c.floor <= af && c.up)) begin
      r = 1'b0;
    end else begin
      r = 1'b1;
    end
    return r;
  endfunction

  entry_t mem [DEPTH];

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic [ADDR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  logic                found_r, found_nxt;
  logic                dup_r, dup_nxt;
  logic [FLOOR_W-1:0]  prev_r, prev_nxt;
  logic [FLOOR_W-1:0]  served_r, served_nxt;
  logic [FLOOR_W-1:0]  headf_r, headf_nxt;
  entry_t              new_r, new_nxt;
  entry_t              carry_r, carry_nxt;
  entry_t              head_r;
  logic [STATUS_W-1:0] stat_r, stat_nxt;
  entry_t              rdata_r;

  logic                re;
  logic [ADDR_W-1:0]   ra;
  logic                we;
  logic [ADDR_W-1:0]   wa;
  entry_t              wd;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_head_valid_r;
  entry_t              out_head_r;
  logic [CNT_W-1:0]    out_count_r;

  logic                accept;
  logic                last_rd;
  logic                dup_hit;
  logic                gb;
  logic                car_hit;
  logic                drop;
  logic [FLOOR_W-1:0]  headf_eff;
  logic                out_load;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign last_rd  = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  assign dup_hit = (rdata_r.floor == new_r.floor) && (rdata_r.internal == new_r.internal) &&
                   (new_r.internal || (rdata_r.up == new_r.up));
  assign gb = goes_before(rdata_r, new_r.floor, new_r.internal, new_r.up, prev_r,
                          head_r.floor);

  assign car_hit = (in_car_floor == in_request_floor) &&
                   ((count_r == '0) || in_is_internal ||
                    (in_going_up && head_r.floor > in_car_floor) ||
                    (!in_going_up && head_r.floor < in_car_floor));

  assign headf_eff = (idx_r == ADDR_W'(1)) ? rdata_r.floor : headf_r;
  assign drop = (rdata_r.floor == served_r) &&
                ((headf_eff <= served_r && !rdata_r.up) ||
                 (headf_eff >= served_r && rdata_r.up));

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    wr_ptr_nxt = wr_ptr_r;
    pos_nxt    = pos_r;
    found_nxt  = found_r;
    dup_nxt    = dup_r;
    prev_nxt   = prev_r;
    served_nxt = served_r;
    headf_nxt  = headf_r;
    new_nxt    = new_r;
    carry_nxt  = carry_r;
    stat_nxt   = stat_r;
    re         = 1'b0;
    ra         = '0;
    we         = 1'b0;
    wa         = '0;
    wd         = carry_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          new_nxt.floor    = in_request_floor;
          new_nxt.internal = in_is_internal;
          new_nxt.up       = in_going_up;
          carry_nxt        = new_nxt;
          if (in_action == ACT_SERVE) begin
            served_nxt = head_r.floor;
            if (count_r == '0) begin
              stat_nxt  = ST_EMPTY;
              state_nxt = S_FIN;
            end else if (count_r == CNT_W'(1)) begin
              count_nxt = '0;
              stat_nxt  = ST_DONE;
              state_nxt = S_FIN;
            end else begin
              re         = 1'b1;
              ra         = ADDR_W'(1);
              idx_nxt    = ADDR_W'(1);
              wr_ptr_nxt = '0;
              state_nxt  = S_SRV;
            end
          end else begin
            if (({1'b0, in_request_floor} >= (FLOOR_W + 1)'(FLOORS)) || car_hit) begin
              stat_nxt  = ST_REDUNDANT;
              state_nxt = S_FIN;
            end else if (count_r == '0) begin
              state_nxt = S_TAIL;
            end else begin
              re        = 1'b1;
              ra        = '0;
              idx_nxt   = '0;
              prev_nxt  = in_car_floor;
              found_nxt = 1'b0;
              dup_nxt   = 1'b0;
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        dup_nxt  = dup_r | dup_hit;
        prev_nxt = rdata_r.floor;
        if (!found_r && gb) begin
          found_nxt = 1'b1;
          pos_nxt   = idx_r;
        end
        if (last_rd) begin
          if (dup_nxt) begin
            stat_nxt  = ST_REDUNDANT;
            state_nxt = S_FIN;
          end else if (count_r == CNT_W'(DEPTH)) begin
            stat_nxt  = ST_FULL;
            state_nxt = S_FIN;
          end else if (found_nxt) begin
            re        = 1'b1;
            ra        = pos_nxt;
            idx_nxt   = pos_nxt;
            carry_nxt = new_r;
            state_nxt = S_SHIFT;
          end else begin
            carry_nxt = new_r;
            state_nxt = S_TAIL;
          end
        end else begin
          re      = 1'b1;
          ra      = idx_r + ADDR_W'(1);
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end
      S_SHIFT: begin
        we        = 1'b1;
        wa        = idx_r;
        wd        = carry_r;
        carry_nxt = rdata_r;
        if (last_rd) begin
          state_nxt = S_TAIL;
        end else begin
          re      = 1'b1;
          ra      = idx_r + ADDR_W'(1);
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end
      S_TAIL: begin
        we        = 1'b1;
        wa        = count_r[ADDR_W-1:0];
        wd        = carry_r;
        count_nxt = count_r + CNT_W'(1);
        stat_nxt  = ST_DONE;
        state_nxt = S_FIN;
      end
      S_SRV: begin
        headf_nxt = headf_eff;
        if (!drop) begin
          we         = 1'b1;
          wa         = wr_ptr_r;
          wd         = rdata_r;
          wr_ptr_nxt = wr_ptr_r + ADDR_W'(1);
        end
        if (last_rd) begin
          count_nxt = CNT_W'(wr_ptr_r) + CNT_W'(!drop);
          stat_nxt  = ST_DONE;
          state_nxt = S_FIN;
        end else begin
          re      = 1'b1;
          ra      = idx_r + ADDR_W'(1);
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    wr_ptr_r <= wr_ptr_nxt;
    pos_r    <= pos_nxt;
    found_r  <= found_nxt;
    dup_r    <= dup_nxt;
    prev_r   <= prev_nxt;
    served_r <= served_nxt;
    headf_r  <= headf_nxt;
    new_r    <= new_nxt;
    carry_r  <= carry_nxt;
    stat_r   <= stat_nxt;
    if (we && wa == '0) begin
      head_r <= wd;
    end
    if (out_load) begin
      out_status_r     <= stat_r;
      out_head_valid_r <= (count_r != '0);
      out_head_r       <= (count_r != '0) ? head_r : '0;
      out_count_r      <= count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_head_valid    = out_head_valid_r;
  assign out_head_floor    = out_head_r.floor;
  assign out_head_internal = out_head_r.internal;
  assign out_head_up       = out_head_r.up;
  assign out_entry_count   = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond list depth");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(we && re && wa == ra))
    else $error("read and write of the same entry in one cycle");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_SHIFT || state_r == S_SRV) |-> count_r != '0)
    else $error("list walk on an empty list");

  a_head_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_head_valid_r == (out_count_r != '0)))
    else $error("head flag disagrees with entry count");

  a_serve_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRV && state_nxt == S_FIN) |=> count_r < $past(count_r))
    else $error("serve did not shrink the list");

endmodule
